/* rtl/core/lsre_pkg.sv */
package lsre_pkg;

    // Item function codes.
    localparam logic [2:0] FN_LSP_HDR   = 3'd0;
    localparam logic [2:0] FN_LSP_ENTRY = 3'd1;
    localparam logic [2:0] FN_OWN_CLEAR = 3'd2;
    localparam logic [2:0] FN_OWN_ENTRY = 3'd3;
    localparam logic [2:0] FN_COMPUTE   = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_ROUTE  = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

    localparam logic [15:0] COST_MAX = 16'hFFFF;

    // Read-modify-write operations on one adjacency row.
    typedef enum logic [1:0] {
        ROW_SET,
        ROW_CLR_BIT,
        ROW_ZERO
    } row_op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_DROP,
        ST_STATUS,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_PICK,
        ST_RELAX,
        ST_RELAX_WAIT,
        ST_OUT_RD,
        ST_OUT_EMIT,
        ST_NONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic hdr_commit;
        logic lsp_close;
        logic nbr_clear;
        logic nbr_write;
        logic set_half;
        logic half_sel;
        logic drop_step;
        logic clr_step;
        logic cnt_clr;
        logic cnt_inc;
        logic cmp_init;
        logic scan_issue;
        logic relax_issue;
        logic pick;
        logic row_load;
        logic out_issue;
        logic emit_route;
        logic emit_status;
        logic emit_none;
        logic acc;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       hdr_ok;
        logic       ent_ok;
        logic       own_ok;
        logic       oent_ok;
        logic       root_ok;
        logic       cnt_end;
        logic       found;
        logic       any_route;
        logic       out_hit;
        logic       out_free;
    } sts_t;

endpackage

/* rtl/core/lsre_ctrl.sv */
module lsre_ctrl
    import lsre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   acc_reg;
    logic   acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            acc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cmd        = '0;
        cmd.acc    = acc_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.cnt_end)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.cnt_clr   = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                acc_next   = 1'b0;
                state_next = ST_STATUS;
                case (sts.func)
                    FN_LSP_HDR:
                    begin
                        if (sts.hdr_ok)
                        begin
                            cmd.hdr_commit = 1'b1;
                            acc_next       = 1'b1;
                            state_next     = ST_DROP;
                        end
                        else
                        begin
                            cmd.lsp_close = 1'b1;
                        end
                    end
                    FN_LSP_ENTRY:
                    begin
                        if (sts.ent_ok)
                        begin
                            acc_next   = 1'b1;
                            state_next = ST_EDGE_A;
                        end
                    end
                    FN_OWN_CLEAR:
                    begin
                        if (sts.own_ok)
                        begin
                            cmd.nbr_clear = 1'b1;
                            acc_next      = 1'b1;
                            state_next    = ST_DROP;
                        end
                    end
                    FN_OWN_ENTRY:
                    begin
                        if (sts.oent_ok)
                        begin
                            cmd.nbr_write = 1'b1;
                            acc_next      = 1'b1;
                            state_next    = ST_EDGE_A;
                        end
                    end
                    FN_COMPUTE:
                    begin
                        if (sts.root_ok)
                        begin
                            cmd.cmp_init = 1'b1;
                            state_next   = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_NONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_STATUS;
                    end
                endcase
            end
            ST_EDGE_A:
            begin
                cmd.set_half = 1'b1;
                cmd.half_sel = 1'b0;
                state_next   = ST_EDGE_B;
            end
            ST_EDGE_B:
            begin
                cmd.set_half = 1'b1;
                cmd.half_sel = 1'b1;
                state_next   = ST_STATUS;
            end
            ST_DROP:
            begin
                cmd.drop_step = 1'b1;
                if (sts.cnt_end)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_STATUS;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_STATUS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.cnt_end)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_SCAN_WAIT;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_SCAN_WAIT:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (sts.found)
                begin
                    cmd.pick     = 1'b1;
                    cmd.row_load = 1'b1;
                    state_next   = ST_RELAX;
                end
                else if (sts.any_route)
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_NONE;
                end
            end
            ST_RELAX:
            begin
                cmd.relax_issue = 1'b1;
                if (sts.cnt_end)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_RELAX_WAIT;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_RELAX_WAIT:
            begin
                state_next = ST_SCAN;
            end
            ST_OUT_RD:
            begin
                cmd.out_issue = 1'b1;
                state_next    = ST_OUT_EMIT;
            end
            ST_OUT_EMIT:
            begin
                if (!sts.out_hit || sts.out_free)
                begin
                    cmd.emit_route = sts.out_hit;
                    if (sts.cnt_end)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = ST_OUT_RD;
                    end
                end
            end
            ST_NONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/lsre_dpath.sv */
module lsre_dpath
    import lsre_pkg::*;
#(
    parameter int MAX_NODES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic [2:0]  func,
    input  logic [4:0]  node_id,
    input  logic [15:0] seq,
    input  logic [15:0] cost,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [1:0]  kind,
    output logic        accepted,
    output logic [4:0]  dest_id,
    output logic [15:0] distance,
    output logic [4:0]  via_id,
    output logic        last,
    input  cmd_t        cmd,
    output sts_t        sts
);

    localparam int NW     = $clog2(MAX_NODES);
    localparam int IW     = (NW > 5) ? NW : 5;
    localparam int AW     = 2 * NW;
    localparam int CDEPTH = 1 << AW;

    // Item and configuration.
    logic [2:0]  func_reg;
    logic [4:0]  id_reg;
    logic [15:0] seq_reg;
    logic [15:0] cost_reg;
    logic [4:0]  own_id_reg;

    // Database state.
    logic                 lsp_open_reg;
    logic [NW-1:0]        lsp_src_reg;
    logic [MAX_NODES-1:0] seen_reg;
    logic [MAX_NODES-1:0] np_reg;
    logic [15:0]          seq_mem   [0:MAX_NODES-1];
    logic [15:0]          ncost_mem [0:MAX_NODES-1];
    logic [MAX_NODES-1:0] row_mem   [0:MAX_NODES-1];
    logic [15:0]          cost_mem  [0:CDEPTH-1];
    logic [15:0]          seq_rd_reg;

    // Row read-modify-write.
    logic [MAX_NODES-1:0] row_rd_reg;
    logic                 pend_vld_reg;
    logic [NW-1:0]        pend_addr_reg;
    row_op_t              pend_op_reg;
    logic [NW-1:0]        pend_bit_reg;
    logic [MAX_NODES-1:0] row_wval;
    logic                 row_rd_en;
    logic [NW-1:0]        row_raddr;

    // Shortest-path work tables.
    logic [15:0]          pdist_mem [0:MAX_NODES-1];
    logic [NW-1:0]        phop_mem  [0:MAX_NODES-1];
    logic [MAX_NODES-1:0] known_reg;
    logic [MAX_NODES-1:0] done_reg;
    logic [MAX_NODES-1:0] direct_reg;
    logic [15:0]          ncost_rd_reg;
    logic [15:0]          pdist_rd_reg;
    logic [NW-1:0]        phop_rd_reg;
    logic [15:0]          cost_rd_reg;
    logic                 rd_vld_reg;
    logic                 rd_relax_reg;
    logic [NW-1:0]        rd_idx_reg;
    logic                 found_reg;
    logic [NW-1:0]        best_reg;
    logic [15:0]          best_dist_reg;
    logic [NW-1:0]        best_hop_reg;
    logic [NW-1:0]        cnt_reg;

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic        acc_reg;
    logic [4:0]  dest_reg;
    logic [15:0] dist_reg;
    logic [4:0]  hop_reg;
    logic        last_reg;

    logic [IW-1:0]        id_ext;
    logic [IW-1:0]        own_ext;
    logic [IW-1:0]        in_ext;
    logic [NW-1:0]        id_idx;
    logic [NW-1:0]        own_idx;
    logic [NW-1:0]        in_idx;
    logic                 id_in;
    logic                 own_in;
    logic [MAX_NODES-1:0] root_vec;
    logic [MAX_NODES-1:0] reach_vec;
    logic [NW-1:0]        edge_a;
    logic [NW-1:0]        edge_b;
    logic [NW-1:0]        half_a;
    logic [NW-1:0]        half_b;
    logic [NW-1:0]        drop_n;
    logic [15:0]          d_v;
    logic [NW-1:0]        h_v;
    logic [16:0]          sum;
    logic [15:0]          nd;
    logic                 better;
    logic                 upd;
    logic                 rd_en;
    logic                 out_free;
    logic                 last_route;
    logic [IW-1:0]        cnt_ext;
    logic [IW-1:0]        hop_ext;

    assign id_ext  = IW'(id_reg);
    assign own_ext = IW'(own_id_reg);
    assign in_ext  = IW'(node_id);
    assign id_idx  = id_ext[NW-1:0];
    assign own_idx = own_ext[NW-1:0];
    assign in_idx  = in_ext[NW-1:0];
    assign id_in   = int'(id_reg) < MAX_NODES;
    assign own_in  = int'(own_id_reg) < MAX_NODES;

    assign root_vec  = own_in ? ({{(MAX_NODES-1){1'b0}}, 1'b1} << own_idx) : '0;
    assign reach_vec = known_reg & ~root_vec;

    assign edge_a = (func_reg == FN_OWN_ENTRY) ? own_idx : lsp_src_reg;
    assign edge_b = id_idx;
    assign half_a = cmd.half_sel ? edge_b : edge_a;
    assign half_b = cmd.half_sel ? edge_a : edge_b;
    assign drop_n = (func_reg == FN_LSP_HDR) ? id_idx : own_idx;

    // Status to the controller.
    assign sts.func      = func_reg;
    assign sts.hdr_ok    = id_in && !(seen_reg[id_idx] && (seq_rd_reg >= seq_reg));
    assign sts.ent_ok    = lsp_open_reg && id_in;
    assign sts.own_ok    = own_in;
    assign sts.oent_ok   = own_in && id_in && (id_reg != own_id_reg);
    assign sts.root_ok   = own_in;
    assign sts.cnt_end   = (cnt_reg == NW'(MAX_NODES - 1));
    assign sts.found     = found_reg;
    assign sts.any_route = |reach_vec;
    assign sts.out_hit   = reach_vec[cnt_reg];
    assign sts.out_free  = out_free;

    assign out_free   = !out_valid_reg || !out_stall;
    assign last_route = ((reach_vec >> cnt_reg) >> 1) == '0;

    // Item, configuration and database control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg   <= '0;
            lsp_open_reg <= 1'b0;
            lsp_src_reg  <= '0;
            seen_reg     <= '0;
            np_reg       <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                own_id_reg <= cfg_wr_data;
            end
            if (cmd.hdr_commit)
            begin
                seen_reg[id_idx] <= 1'b1;
                lsp_open_reg     <= 1'b1;
                lsp_src_reg      <= id_idx;
            end
            else if (cmd.lsp_close)
            begin
                lsp_open_reg <= 1'b0;
            end
            if (cmd.nbr_clear)
            begin
                np_reg <= '0;
            end
            else if (cmd.nbr_write)
            begin
                np_reg[id_idx] <= 1'b1;
            end
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg   <= func;
            id_reg     <= node_id;
            seq_reg    <= seq;
            cost_reg   <= cost;
            seq_rd_reg <= seq_mem[in_idx];
        end
        if (cmd.hdr_commit)
        begin
            seq_mem[id_idx] <= seq_reg;
        end
        if (cmd.nbr_write)
        begin
            ncost_mem[id_idx] <= cost_reg;
        end
    end

    // Adjacency rows: one read and one write a cycle, with the pending write forwarded.
    always_comb
    begin
        row_rd_en = 1'b0;
        row_raddr = cnt_reg;
        if (cmd.set_half)
        begin
            row_rd_en = 1'b1;
            row_raddr = half_a;
        end
        else if (cmd.drop_step)
        begin
            row_rd_en = 1'b1;
            row_raddr = cnt_reg;
        end
        else if (cmd.row_load)
        begin
            row_rd_en = 1'b1;
            row_raddr = best_reg;
        end
    end

    always_comb
    begin
        case (pend_op_reg)
            ROW_SET:     row_wval = row_rd_reg | ({{(MAX_NODES-1){1'b0}}, 1'b1} << pend_bit_reg);
            ROW_CLR_BIT: row_wval = row_rd_reg & ~({{(MAX_NODES-1){1'b0}}, 1'b1} << pend_bit_reg);
            default:     row_wval = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            pend_vld_reg <= cmd.set_half || cmd.drop_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_half)
        begin
            pend_addr_reg <= half_a;
            pend_op_reg   <= ROW_SET;
            pend_bit_reg  <= half_b;
        end
        else if (cmd.drop_step)
        begin
            pend_addr_reg <= cnt_reg;
            pend_op_reg   <= (cnt_reg == drop_n) ? ROW_ZERO : ROW_CLR_BIT;
            pend_bit_reg  <= drop_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            row_mem[cnt_reg] <= '0;
        end
        else if (pend_vld_reg)
        begin
            row_mem[pend_addr_reg] <= row_wval;
        end
        if (row_rd_en)
        begin
            if (pend_vld_reg && (pend_addr_reg == row_raddr))
            begin
                row_rd_reg <= row_wval;
            end
            else
            begin
                row_rd_reg <= row_mem[row_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_half)
        begin
            cost_mem[{half_a, half_b}] <= cost_reg;
        end
        if (cmd.relax_issue)
        begin
            cost_rd_reg <= cost_mem[{best_reg, cnt_reg}];
        end
    end

    // Per-node reads for scan, relaxation and route output.
    assign rd_en = cmd.scan_issue || cmd.relax_issue || cmd.out_issue;

    assign d_v = direct_reg[rd_idx_reg] ? ncost_rd_reg : pdist_rd_reg;
    assign h_v = direct_reg[rd_idx_reg] ? rd_idx_reg : phop_rd_reg;
    assign sum = {1'b0, best_dist_reg} + {1'b0, cost_rd_reg};
    assign nd  = sum[16] ? COST_MAX : sum[15:0];

    assign better = rd_vld_reg && !rd_relax_reg && known_reg[rd_idx_reg]
                    && !done_reg[rd_idx_reg] && (!found_reg || (d_v < best_dist_reg));
    assign upd    = rd_vld_reg && rd_relax_reg && row_rd_reg[rd_idx_reg]
                    && !done_reg[rd_idx_reg]
                    && (!known_reg[rd_idx_reg] || (d_v > nd));

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ncost_rd_reg <= ncost_mem[cnt_reg];
            pdist_rd_reg <= pdist_mem[cnt_reg];
            phop_rd_reg  <= phop_mem[cnt_reg];
            rd_idx_reg   <= cnt_reg;
        end
        if (upd)
        begin
            pdist_mem[rd_idx_reg] <= nd;
            phop_mem[rd_idx_reg]  <= best_hop_reg;
        end
        if (better)
        begin
            best_reg      <= rd_idx_reg;
            best_dist_reg <= d_v;
            best_hop_reg  <= h_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            rd_relax_reg <= 1'b0;
            known_reg    <= '0;
            done_reg     <= '0;
            direct_reg   <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= cmd.scan_issue || cmd.relax_issue;
            rd_relax_reg <= cmd.relax_issue;
            if (cmd.cmp_init)
            begin
                known_reg  <= np_reg & ~root_vec;
                direct_reg <= np_reg & ~root_vec;
                done_reg   <= root_vec;
                found_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.pick)
                begin
                    done_reg[best_reg] <= 1'b1;
                    found_reg          <= 1'b0;
                end
                else if (better)
                begin
                    found_reg <= 1'b1;
                end
                if (upd)
                begin
                    known_reg[rd_idx_reg]  <= 1'b1;
                    direct_reg[rd_idx_reg] <= 1'b0;
                end
            end
        end
    end

    // Output register.
    assign cnt_ext = IW'(cnt_reg);
    assign hop_ext = IW'(h_v);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_route || cmd.emit_status || cmd.emit_none)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_route)
        begin
            kind_reg <= KIND_ROUTE;
            acc_reg  <= 1'b1;
            dest_reg <= cnt_ext[4:0];
            dist_reg <= d_v;
            hop_reg  <= hop_ext[4:0];
            last_reg <= last_route;
        end
        else if (cmd.emit_status || cmd.emit_none)
        begin
            kind_reg <= cmd.emit_status ? KIND_STATUS : KIND_NONE;
            acc_reg  <= cmd.emit_status ? cmd.acc : 1'b0;
            dest_reg <= '0;
            dist_reg <= '0;
            hop_reg  <= '0;
            last_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign accepted  = acc_reg;
    assign dest_id   = dest_reg;
    assign distance  = dist_reg;
    assign via_id    = hop_reg;
    assign last      = last_reg;

endmodule

/* rtl/core/link_state_route_engine.sv */
// Link-state route engine. It keeps a link-state database for up to MAX_NODES
// routers and computes shortest paths from own_id, written through cfg_wr_en
// and cfg_wr_data; the user must write it only while the block is idle, as
// the block does not enforce this. Every input item is taken on its own and
// is answered with one status transfer, except a compute item, which answers
// with one route transfer per reachable destination in ascending id order
// (the final one has last set), or a single no-destination transfer. After
// reset the adjacency rows are swept clear before the first transfer is
// taken. A neighbour entry or own link entry makes two read-modify-writes of
// adjacency rows; a header or a clear of own links sweeps the adjacency
// memory, clearing that node's column in every row. A compute item runs a
// one-node-a-cycle minimum scan and relaxation over the distance tables for
// each reachable node, then a closing scan that finds nothing left, then
// reads the routes out; out_stall can hold a result back.
module link_state_route_engine
    import lsre_pkg::*;
#(
    parameter int MAX_NODES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [4:0]  node_id,
    input  logic [15:0] seq,
    input  logic [15:0] cost,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic        accepted,
    output logic [4:0]  dest_id,
    output logic [15:0] distance,
    output logic [4:0]  via_id,
    output logic        last
);

    cmd_t cmd;
    sts_t sts;

    // The controller sequences each item; it stalls the input transfer
    // whenever it is not waiting for a new item.
    lsre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the database memories, the shortest-path work
    // tables and the output register.
    lsre_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .func        (func),
        .node_id     (node_id),
        .seq         (seq),
        .cost        (cost),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .kind        (kind),
        .accepted    (accepted),
        .dest_id     (dest_id),
        .distance    (distance),
        .via_id      (via_id),
        .last        (last),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
